FILE: sv/twdsm_pkg.sv
// Shared types and constants of the two-wire display serial master.
package twdsm_pkg;

    // Command codes carried in the input item's selector field.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_SEND  = 2'd3
    } op_t;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST0,
        PH_ST1,
        PH_ST2,
        PH_ST3,
        PH_SP0,
        PH_SP1,
        PH_SP2,
        PH_SP3,
        PH_TX_SETUP,
        PH_TX_HIGH,
        PH_ACK0,
        PH_ACK1,
        PH_ACK_HIGH,
        PH_TAIL
    } phase_t;

    // Result item, clk_level in the lowest bit.
    typedef struct packed {
        logic ack;
        logic done_res;
        logic busy_res;
        logic dio_drive;
        logic dio_level;
        logic clk_drive;
        logic clk_level;
    } result_t;

    localparam int unsigned HP_WIDTH     = 16;
    localparam int unsigned BYTE_WIDTH   = 8;
    localparam int unsigned BIT_IDX_W    = 3;
    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned APB_ADDR_W   = 2;
    localparam int unsigned S_TDATA_W    = 16;
    localparam int unsigned M_TDATA_W    = 8;

    localparam logic [HP_WIDTH-1:0]   HP_RESET     = 16'd50;
    localparam logic [APB_ADDR_W-1:0] ADDR_HALF_PERIOD = 2'd0;
    localparam logic [BIT_IDX_W-1:0]  LAST_BIT     = 3'd7;

endpackage

FILE: sv/twdsm_regs.sv
// Configuration register file behind the APB-style port.
module twdsm_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [twdsm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [twdsm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [twdsm_pkg::APB_DATA_W-1:0]      prdata,
    output logic [twdsm_pkg::HP_WIDTH-1:0]        half_period
);

    logic [twdsm_pkg::HP_WIDTH-1:0] half_period_reg;
    logic                           wr_en;

    assign wr_en = psel && penable && pwrite && (paddr == twdsm_pkg::ADDR_HALF_PERIOD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= twdsm_pkg::HP_RESET;
        end else if (wr_en) begin
            half_period_reg <= pwdata[twdsm_pkg::HP_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == twdsm_pkg::ADDR_HALF_PERIOD) begin
            prdata = {{(twdsm_pkg::APB_DATA_W-twdsm_pkg::HP_WIDTH){1'b0}}, half_period_reg};
        end
    end

    assign half_period = half_period_reg;

endmodule

FILE: sv/twdsm_seq.sv
// Line sequencer: phase, tick counter, shift register and line latches.
module twdsm_seq (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  twdsm_pkg::op_t                       op,
    input  logic [twdsm_pkg::BYTE_WIDTH-1:0]     data_byte,
    input  logic                                 dio_in,
    input  logic [twdsm_pkg::HP_WIDTH-1:0]       half_period,
    output twdsm_pkg::result_t                   result
);

    twdsm_pkg::phase_t                 phase_reg, phase_next;
    logic [twdsm_pkg::HP_WIDTH-1:0]    tick_count_reg, tick_count_next;
    logic [twdsm_pkg::BIT_IDX_W-1:0]   bit_index_reg, bit_index_next;
    logic [twdsm_pkg::BYTE_WIDTH-1:0]  shift_reg, shift_next;
    logic                              ack_reg, ack_next;
    logic                              clk_lvl_reg, clk_lvl_next;
    logic                              clk_drv_reg, clk_drv_next;
    logic                              dio_lvl_reg, dio_lvl_next;
    logic                              dio_drv_reg, dio_drv_next;
    logic [twdsm_pkg::HP_WIDTH-1:0]    limit;
    logic [twdsm_pkg::HP_WIDTH-1:0]    cnt_inc;
    logic                              done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= twdsm_pkg::PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            ack_reg        <= 1'b0;
            clk_lvl_reg    <= 1'b0;
            clk_drv_reg    <= 1'b0;
            dio_lvl_reg    <= 1'b0;
            dio_drv_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            ack_reg        <= ack_next;
            clk_lvl_reg    <= clk_lvl_next;
            clk_drv_reg    <= clk_drv_next;
            dio_lvl_reg    <= dio_lvl_next;
            dio_drv_reg    <= dio_drv_next;
        end
    end

    // A zero half period behaves as one tick.
    assign limit   = (half_period == '0) ? twdsm_pkg::HP_WIDTH'(1) : half_period;
    assign cnt_inc = twdsm_pkg::HP_WIDTH'(tick_count_reg + 1'b1);

    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        ack_next        = ack_reg;
        clk_lvl_next    = clk_lvl_reg;
        clk_drv_next    = clk_drv_reg;
        dio_lvl_next    = dio_lvl_reg;
        dio_drv_next    = dio_drv_reg;
        done            = 1'b0;

        if (accept) begin
            if (phase_reg == twdsm_pkg::PH_IDLE) begin
                tick_count_next = '0;
                case (op)
                    twdsm_pkg::OP_START: begin
                        dio_drv_next = 1'b1;
                        dio_lvl_next = 1'b0;
                        phase_next   = twdsm_pkg::PH_ST0;
                    end
                    twdsm_pkg::OP_STOP: begin
                        clk_drv_next = 1'b1;
                        clk_lvl_next = 1'b1;
                        dio_drv_next = 1'b1;
                        phase_next   = twdsm_pkg::PH_SP0;
                    end
                    twdsm_pkg::OP_SEND: begin
                        clk_drv_next   = 1'b1;
                        dio_drv_next   = 1'b1;
                        shift_next     = data_byte;
                        bit_index_next = '0;
                        dio_lvl_next   = data_byte[0];
                        phase_next     = twdsm_pkg::PH_TX_SETUP;
                    end
                    default: ;
                endcase
            end else if (op == twdsm_pkg::OP_TICK) begin
                tick_count_next = cnt_inc;
                if (cnt_inc >= limit) begin
                    tick_count_next = '0;
                    case (phase_reg)
                        twdsm_pkg::PH_ST0: phase_next = twdsm_pkg::PH_ST1;
                        twdsm_pkg::PH_ST1: begin
                            clk_drv_next = 1'b1;
                            clk_lvl_next = 1'b0;
                            phase_next   = twdsm_pkg::PH_ST2;
                        end
                        twdsm_pkg::PH_ST2: phase_next = twdsm_pkg::PH_ST3;
                        twdsm_pkg::PH_SP0: phase_next = twdsm_pkg::PH_SP1;
                        twdsm_pkg::PH_SP1: begin
                            dio_lvl_next = 1'b1;
                            phase_next   = twdsm_pkg::PH_SP2;
                        end
                        twdsm_pkg::PH_SP2: phase_next = twdsm_pkg::PH_SP3;
                        twdsm_pkg::PH_SP3: begin
                            clk_drv_next = 1'b0;
                            dio_drv_next = 1'b0;
                            phase_next   = twdsm_pkg::PH_IDLE;
                            done         = 1'b1;
                        end
                        twdsm_pkg::PH_TX_SETUP: begin
                            clk_lvl_next = 1'b1;
                            phase_next   = twdsm_pkg::PH_TX_HIGH;
                        end
                        twdsm_pkg::PH_TX_HIGH: begin
                            clk_lvl_next = 1'b0;
                            shift_next   = {1'b0, shift_reg[twdsm_pkg::BYTE_WIDTH-1:1]};
                            if (bit_index_reg == twdsm_pkg::LAST_BIT) begin
                                bit_index_next = '0;
                                dio_drv_next   = 1'b0;
                                phase_next     = twdsm_pkg::PH_ACK0;
                            end else begin
                                bit_index_next = bit_index_reg + 1'b1;
                                dio_lvl_next   = shift_reg[1];
                                phase_next     = twdsm_pkg::PH_TX_SETUP;
                            end
                        end
                        twdsm_pkg::PH_ACK0: phase_next = twdsm_pkg::PH_ACK1;
                        twdsm_pkg::PH_ACK1: begin
                            ack_next     = ~dio_in;
                            clk_lvl_next = 1'b1;
                            phase_next   = twdsm_pkg::PH_ACK_HIGH;
                        end
                        twdsm_pkg::PH_ACK_HIGH: begin
                            clk_lvl_next = 1'b0;
                            dio_lvl_next = 1'b0;
                            dio_drv_next = 1'b1;
                            phase_next   = twdsm_pkg::PH_TAIL;
                        end
                        default: begin
                            // end of start and end of byte tail
                            phase_next = twdsm_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        result.clk_level = clk_lvl_next;
        result.clk_drive = clk_drv_next;
        result.dio_level = dio_lvl_next;
        result.dio_drive = dio_drv_next;
        result.busy_res  = (phase_next != twdsm_pkg::PH_IDLE);
        result.done_res  = done;
        result.ack       = ack_next;
    end

endmodule

FILE: sv/twdsm_skid.sv
// Output register with a skid stage for the result channel.
module twdsm_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  twdsm_pkg::result_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output twdsm_pkg::result_t  out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    twdsm_pkg::result_t out_data_reg;
    twdsm_pkg::result_t skid_data_reg;
    logic               out_free;

    assign in_ready = !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && in_ready) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/two_wire_display_serial_master_core.sv
// Two-wire display serial master: top level.
//
// Input channel (s_): one item per handshake. s_tuser holds the command
// (tick, start, stop, send byte); s_tdata holds the byte to send and the
// sampled data line level. Commands act only while the sequencer is idle;
// a tick advances the half-period counter of a running sequence.
// Result channel (m_): exactly one item per input item, carrying the line
// levels and drive enables after that item, plus busy, done and ack.
// The result of an item is registered before it is offered on m_.
// Throughput: one item per cycle while s_tready is high; the sequencer updates in the same cycle
// the item is accepted and the result lands in the output register or the skid.
// When the receiver stalls, one further result is held in a skid stage and
// s_tready drops only once both the output register and the skid are full.
// Reset (aresetn low, synchronous): sequencer idle, both lines released
// with latches low, ack cleared, half period back to 50 ticks, no result
// pending. Write half_period_ticks at address 0 through the APB port.
module two_wire_display_serial_master_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [twdsm_pkg::S_TDATA_W-1:0]       s_tdata,  // [7:0] data_byte, [8] dio_in
    input  logic [1:0]                            s_tuser,  // [1:0] operation
    // result channel
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] clk_level, [1] clk_drive, [2] dio_level, [3] dio_drive,
    // [4] busy_res, [5] done_res, [6] ack
    output logic [twdsm_pkg::M_TDATA_W-1:0]       m_tdata,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [twdsm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [twdsm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [twdsm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    logic [twdsm_pkg::HP_WIDTH-1:0] half_period;
    logic                           accept;
    twdsm_pkg::result_t             seq_result;
    twdsm_pkg::result_t             out_result;

    // Register writes complete in the access cycle.
    assign pready = 1'b1;

    twdsm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .half_period (half_period)
    );

    assign accept = s_tvalid && s_tready;

    // Sequencer state updates only on accepted items.
    twdsm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (twdsm_pkg::op_t'(s_tuser)),
        .data_byte   (s_tdata[twdsm_pkg::BYTE_WIDTH-1:0]),
        .dio_in      (s_tdata[twdsm_pkg::BYTE_WIDTH]),
        .half_period (half_period),
        .result      (seq_result)
    );

    // Hold results here while the receiver stalls.
    twdsm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (seq_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(twdsm_pkg::M_TDATA_W - $bits(twdsm_pkg::result_t)){1'b0}}, out_result};

endmodule

FILE: sv/twdsm_checker.sv
// Port-level checker for the serial master, bound to the top level.
module twdsm_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [twdsm_pkg::M_TDATA_W-1:0]       m_tdata,
    input logic                                  psel,
    input logic                                  penable,
    input logic                                  pwrite,
    input logic [twdsm_pkg::APB_ADDR_W-1:0]      paddr,
    input logic [twdsm_pkg::APB_DATA_W-1:0]      pwdata,
    input logic [twdsm_pkg::APB_DATA_W-1:0]      prdata
);

    // No result may be pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input side backs up only when the output holds a result.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // A finishing item always leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[5] && m_tdata[4]))
        else $error("done and busy together");

    // A written half period reads back.
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && (paddr == twdsm_pkg::ADDR_HALF_PERIOD)
        |=> (paddr != twdsm_pkg::ADDR_HALF_PERIOD)
            || (prdata[twdsm_pkg::HP_WIDTH-1:0] == $past(pwdata[twdsm_pkg::HP_WIDTH-1:0])))
        else $error("half period readback mismatch");

endmodule

bind two_wire_display_serial_master_core twdsm_checker u_twdsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

FILE: test/testbench.sv
// Self-checking testbench for the two-wire display serial master core.
`timescale 1ns / 1ps

module testbench;

    // One row of the opening table: the item to send and, where it is plain
    // to see, the result that must come back for it.
    typedef struct packed {
        twdsm_pkg::op_t                   op;
        logic [twdsm_pkg::BYTE_WIDTH-1:0] data_byte;
        logic                             dio_in;
        logic                             fixed;   // 1: take want from the table
        twdsm_pkg::result_t               want;
    } bus_row_t;

    localparam int ROW_COUNT = 25;

    // Half period 0 is in force while this table runs, so every tick ends a
    // half period. Fixed results: idle tick, start, send ignored while busy,
    // and a send after a finished stop, which drives the clock with its latch
    // still high.
    localparam bus_row_t OPENING_ROWS [ROW_COUNT] = '{
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 7'h00},
        '{twdsm_pkg::OP_START, 8'h00, 1'b0, 1'b1, 7'h18},
        '{twdsm_pkg::OP_SEND,  8'hFF, 1'b1, 1'b1, 7'h18},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_STOP,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_START, 8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_SEND,  8'hFF, 1'b1, 1'b1, 7'h1F},
        '{twdsm_pkg::OP_STOP,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 7'h00},
        '{twdsm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 7'h00}
    };

    // Half periods for the random phases after the first, which runs with 0; 65535 comes last on its own.
    localparam logic [twdsm_pkg::HP_WIDTH-1:0] HALF_PERIOD_PLAN [4] =
        '{16'd1, 16'd3, 16'd2, 16'd5};
    localparam int unsigned ITEMS_PER_PHASE = 300;
    localparam int unsigned HOLD_OFF_CYCLES = 80;

    logic                                aclk     = 1'b0;
    logic                                aresetn  = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [twdsm_pkg::S_TDATA_W-1:0]     s_tdata  = '0;
    logic [1:0]                          s_tuser  = twdsm_pkg::OP_TICK;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [twdsm_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [twdsm_pkg::APB_ADDR_W-1:0]    paddr    = '0;
    logic [twdsm_pkg::APB_DATA_W-1:0]    pwdata   = '0;
    logic [twdsm_pkg::APB_DATA_W-1:0]    prdata;
    logic                                pready;

    two_wire_display_serial_master_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Sequencer mirror, starting from its reset values.
    logic [twdsm_pkg::HP_WIDTH-1:0]   hp_ticks   = twdsm_pkg::HP_RESET;
    twdsm_pkg::phase_t                seq_phase  = twdsm_pkg::PH_IDLE;
    logic [twdsm_pkg::HP_WIDTH-1:0]   tick_cnt   = '0;
    logic [twdsm_pkg::BIT_IDX_W-1:0]  bit_pos    = '0;
    logic [twdsm_pkg::BYTE_WIDTH-1:0] tx_shift   = '0;
    logic                             ack_seen   = 1'b0;
    logic                             scl_lvl    = 1'b0;
    logic                             scl_drv    = 1'b0;
    logic                             sda_lvl    = 1'b0;
    logic                             sda_drv    = 1'b0;

    twdsm_pkg::result_t line_results [$];     // predicted line states, oldest first
    int unsigned mismatch_count = 0;
    logic        rx_holding     = 1'b0; // receiver is in its long hold-off
    int unsigned tx_mode        = 1;
    int unsigned tx_count       = 0;
    string       field_names [7] = '{"clk_level", "clk_drive", "dio_level", "dio_drive",
                                     "busy_res", "done_res", "ack"};

    // Idle cycles before the next item: none, full range, or short.
    function automatic int unsigned draw_gap(input int unsigned mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 11);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    // Move the sequencer on once a half period has elapsed.
    task automatic close_half_period(input logic dio_in, output logic finished);
        finished = 1'b0;
        case (seq_phase)
            twdsm_pkg::PH_ST0: seq_phase = twdsm_pkg::PH_ST1;
            twdsm_pkg::PH_ST1: begin
                scl_drv   = 1'b1;
                scl_lvl   = 1'b0;
                seq_phase = twdsm_pkg::PH_ST2;
            end
            twdsm_pkg::PH_ST2: seq_phase = twdsm_pkg::PH_ST3;
            twdsm_pkg::PH_SP0: seq_phase = twdsm_pkg::PH_SP1;
            twdsm_pkg::PH_SP1: begin
                sda_lvl   = 1'b1;
                seq_phase = twdsm_pkg::PH_SP2;
            end
            twdsm_pkg::PH_SP2: seq_phase = twdsm_pkg::PH_SP3;
            twdsm_pkg::PH_SP3: begin
                scl_drv   = 1'b0;
                sda_drv   = 1'b0;
                seq_phase = twdsm_pkg::PH_IDLE;
                finished  = 1'b1;
            end
            twdsm_pkg::PH_TX_SETUP: begin
                scl_lvl   = 1'b1;
                seq_phase = twdsm_pkg::PH_TX_HIGH;
            end
            twdsm_pkg::PH_TX_HIGH: begin
                scl_lvl  = 1'b0;
                tx_shift = tx_shift >> 1;
                if (bit_pos == twdsm_pkg::LAST_BIT) begin
                    // last bit out: release the data line for the acknowledge
                    bit_pos   = '0;
                    sda_drv   = 1'b0;
                    seq_phase = twdsm_pkg::PH_ACK0;
                end else begin
                    bit_pos   = bit_pos + 3'd1;
                    sda_lvl   = tx_shift[0];
                    seq_phase = twdsm_pkg::PH_TX_SETUP;
                end
            end
            twdsm_pkg::PH_ACK0: seq_phase = twdsm_pkg::PH_ACK1;
            twdsm_pkg::PH_ACK1: begin
                ack_seen  = ~dio_in;
                scl_lvl   = 1'b1;
                seq_phase = twdsm_pkg::PH_ACK_HIGH;
            end
            twdsm_pkg::PH_ACK_HIGH: begin
                scl_lvl   = 1'b0;
                sda_lvl   = 1'b0;
                sda_drv   = 1'b1;
                seq_phase = twdsm_pkg::PH_TAIL;
            end
            default: begin
                // end of start or of the byte tail
                seq_phase = twdsm_pkg::PH_IDLE;
                finished  = 1'b1;
            end
        endcase
    endtask

    // Apply one accepted item to the mirror and return the line state after it.
    task automatic predict_lines(input twdsm_pkg::op_t op,
                                 input logic [twdsm_pkg::BYTE_WIDTH-1:0] data_byte,
                                 input logic dio_in, output twdsm_pkg::result_t lines);
        logic [twdsm_pkg::HP_WIDTH-1:0] limit;
        logic                           finished;
        limit    = (hp_ticks == '0) ? 16'd1 : hp_ticks;
        finished = 1'b0;
        if (seq_phase == twdsm_pkg::PH_IDLE) begin
            tick_cnt = '0;
            case (op)
                twdsm_pkg::OP_START: begin
                    sda_drv   = 1'b1;
                    sda_lvl   = 1'b0;
                    seq_phase = twdsm_pkg::PH_ST0;
                end
                twdsm_pkg::OP_STOP: begin
                    scl_drv   = 1'b1;
                    scl_lvl   = 1'b1;
                    sda_drv   = 1'b1;
                    seq_phase = twdsm_pkg::PH_SP0;
                end
                twdsm_pkg::OP_SEND: begin
                    scl_drv   = 1'b1;
                    sda_drv   = 1'b1;
                    tx_shift  = data_byte;
                    bit_pos   = '0;
                    sda_lvl   = data_byte[0];
                    seq_phase = twdsm_pkg::PH_TX_SETUP;
                end
                default: ;
            endcase
        end else if (op == twdsm_pkg::OP_TICK) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= limit) begin
                tick_cnt = '0;
                close_half_period(dio_in, finished);
            end
        end
        lines.clk_level = scl_lvl;
        lines.clk_drive = scl_drv;
        lines.dio_level = sda_lvl;
        lines.dio_drive = sda_drv;
        lines.busy_res  = (seq_phase != twdsm_pkg::PH_IDLE);
        lines.done_res  = finished;
        lines.ack       = ack_seen;
    endtask

    // Offer one item after a random gap, hold it until accepted, then queue
    // the line state it must produce.
    task automatic offer_item(input twdsm_pkg::op_t op,
                              input logic [twdsm_pkg::BYTE_WIDTH-1:0] data_byte,
                              input logic dio_in, input logic fixed,
                              input twdsm_pkg::result_t want);
        int unsigned        gap;
        twdsm_pkg::result_t lines;
        gap = rx_holding ? 0 : draw_gap(tx_mode);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, dio_in, data_byte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_lines(op, data_byte, dio_in, lines);
        line_results.push_back(fixed ? want : lines);
        tx_count++;
        if (tx_count % 40 == 0) tx_mode = $urandom_range(0, 2);
    endtask

    // Drop the input and wait until every queued result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (line_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic confirm_half_period();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= twdsm_pkg::ADDR_HALF_PERIOD;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {16'd0, hp_ticks}) begin
            $display("%0t: half_period_ticks readback expected %0d actual %0d",
                     $time, hp_ticks, prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_half_period(input logic [twdsm_pkg::HP_WIDTH-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= twdsm_pkg::ADDR_HALF_PERIOD;
        pwdata  <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        hp_ticks = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        confirm_half_period();
    endtask

    // Mostly well-formed traffic: commands while idle, ticks while busy, with
    // some stray ticks and ignored commands mixed in. Stop only when idle.
    task automatic run_random_phase(input int unsigned live_target);
        int unsigned                      live;
        twdsm_pkg::op_t                   op;
        logic [twdsm_pkg::BYTE_WIDTH-1:0] data_byte;
        logic                             dio_in;
        live = 0;
        while (live < live_target || seq_phase != twdsm_pkg::PH_IDLE) begin
            data_byte = 8'($urandom_range(0, 255));
            dio_in    = 1'($urandom_range(0, 1));
            if (seq_phase != twdsm_pkg::PH_IDLE) begin
                if ($urandom_range(0, 7) == 0) begin
                    op = twdsm_pkg::op_t'($urandom_range(1, 3));
                end else begin
                    op = twdsm_pkg::OP_TICK;
                    live++;
                end
            end else if ($urandom_range(0, 3) == 0) begin
                op = twdsm_pkg::OP_TICK;
            end else begin
                op = twdsm_pkg::op_t'($urandom_range(1, 3));
                live++;
            end
            offer_item(op, data_byte, dio_in, 1'b0, '0);
        end
    endtask

    // Main sequence: reset, opening table, random phases, slowest setting.
    initial begin : stimulus
        int unsigned wait_guard;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Check the reset half period, then force the zero case.
        confirm_half_period();
        program_half_period(16'd0);

        foreach (OPENING_ROWS[i]) begin
            offer_item(OPENING_ROWS[i].op, OPENING_ROWS[i].data_byte, OPENING_ROWS[i].dio_in,
                       OPENING_ROWS[i].fixed, OPENING_ROWS[i].want);
        end
        run_random_phase(ITEMS_PER_PHASE);

        foreach (HALF_PERIOD_PLAN[i]) begin
            drain_results();
            program_half_period(HALF_PERIOD_PLAN[i]);
            run_random_phase(ITEMS_PER_PHASE);
        end

        // Longest half period: start a sequence and tick part of its first
        // half, with a few commands that must be ignored.
        drain_results();
        program_half_period(16'hFFFF);
        offer_item(twdsm_pkg::OP_START, 8'h00, 1'b0, 1'b0, '0);
        for (int i = 0; i < 40; i++) begin
            if (i % 13 == 5)
                offer_item(twdsm_pkg::op_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'b0, '0);
            else
                offer_item(twdsm_pkg::OP_TICK, 8'h00, 1'($urandom_range(0, 1)), 1'b0, '0);
        end

        // Wait out the last results, with a bound of our own.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_guard = 0;
        while (line_results.size() != 0 && wait_guard < 20000) begin
            @(posedge aclk);
            wait_guard++;
        end
        repeat (8) @(posedge aclk);
        if (line_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, line_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: random stalls per item, calm stretches, and two long
    // hold-offs that let the block fill up and push back on its input.
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        int unsigned rx_mode;
        taken   = 0;
        rx_mode = 1;
        @(posedge aresetn);
        forever begin
            if (taken == 300 || taken == 1100) begin
                rx_holding = 1'b1;
                gap        = HOLD_OFF_CYCLES;
            end else begin
                gap = draw_gap(rx_mode);
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            rx_holding = 1'b0;
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            if (taken % 40 == 0) rx_mode = $urandom_range(0, 2);
        end
    end

    // Compare each accepted result with the oldest prediction, field by field.
    always @(posedge aclk) begin : result_check
        twdsm_pkg::result_t want;
        twdsm_pkg::result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[6:0];
            if (line_results.size() == 0) begin
                $display("%0t: result with nothing expected: expected none actual %h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = line_results.pop_front();
                for (int i = 0; i < 7; i++) begin
                    if (want[i] !== got[i]) begin
                        $display("%0t: %s expected %b actual %b",
                                 $time, field_names[i], want[i], got[i]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Hard stop in case a handshake never completes.
    initial begin : watchdog
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
